>>> hw/rtl/ephb_pkg.sv
// ----------------------------------------------------------------------------
// ephb_pkg
// Shared types and constants for the event pair binned histogram.
// ----------------------------------------------------------------------------
package ephb_pkg;

  // Configuration register indexes (byte address is four times the index)
  localparam logic [1:0] REG_X_TYPES = 2'd0;
  localparam logic [1:0] REG_Y_TYPES = 2'd1;
  localparam logic [1:0] REG_BINS    = 2'd2;

  // Register reset values
  localparam logic [3:0] X_TYPES_RST = 4'd8;
  localparam logic [3:0] Y_TYPES_RST = 4'd8;
  localparam logic [5:0] BINS_RST    = 6'd32;

  // Highest bin number that the bin counter reaches
  localparam logic [5:0] BIN_CEILING = 6'd63;

  // Width of the count field on the result channel
  localparam int unsigned OUT_COUNT_W = 32;

  // Operation handed from the event stage to the cell store
  typedef struct packed {
    logic inc;  // add one to the addressed cell
    logic rd;   // return the addressed cell
  } ephb_req_t;

endpackage

>>> hw/rtl/ephb_in_if.sv
// ----------------------------------------------------------------------------
// ephb_in_if
// Event / read transaction channel with valid-ready handshake.
// ----------------------------------------------------------------------------
interface ephb_in_if;

  logic       valid;
  logic       ready;
  logic       func;
  logic       is_reset;
  logic       is_break;
  logic       is_bin;
  logic       x_hit;
  logic [2:0] x_index;
  logic       y_hit;
  logic [2:0] y_index;
  logic [4:0] read_bin;
  logic [5:0] read_cell;

  modport source (
    output valid, func, is_reset, is_break, is_bin, x_hit, x_index,
           y_hit, y_index, read_bin, read_cell,
    input  ready
  );

  modport sink (
    input  valid, func, is_reset, is_break, is_bin, x_hit, x_index,
           y_hit, y_index, read_bin, read_cell,
    output ready
  );

endinterface

>>> hw/rtl/ephb_out_if.sv
// ----------------------------------------------------------------------------
// ephb_out_if
// Result transaction channel with valid-ready handshake.
// ----------------------------------------------------------------------------
interface ephb_out_if;

  logic        valid;
  logic        ready;
  logic [31:0] count;
  logic        counted;
  logic        dropped;

  modport source (
    output valid, count, counted, dropped,
    input  ready
  );

  modport sink (
    input  valid, count, counted, dropped,
    output ready
  );

endinterface

>>> hw/rtl/event_pair_binned_histogram.sv
// ----------------------------------------------------------------------------
// event_pair_binned_histogram
// Counts x-then-y event pairs per bin in a memory-held histogram and returns
// single cells on request.
// ----------------------------------------------------------------------------
//  channel   role    handshake              payload
//  in_ch     sink    valid / ready          func, labels, x/y hits, read address
//  out_ch    source  valid / ready          count, counted, dropped
//  APB       slave   psel/penable, pready=1 x_type_count, y_type_count, bins_in_use
//
//  One transaction per cycle while the output is not stalled and the sweep is
//  done; its result passes from the memory read stage into the output register,
//  from which out_ch takes it.
//  The cell memory has one read and one write port; an increment is written
//  back as it leaves the read stage and forwarded to a following read of the
//  same cell.
//  After reset a sweep zeroes all BIN_SLOTS*MAX_X_TYPES*MAX_Y_TYPES entries
//  (2048 by default) with in_ch.ready low; register writes still go.
//  A stalled output holds the register and one item in the read stage.
// ----------------------------------------------------------------------------
module event_pair_binned_histogram #(
  parameter int unsigned BIN_SLOTS   = 32,
  parameter int unsigned MAX_X_TYPES = 8,
  parameter int unsigned MAX_Y_TYPES = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ephb_in_if.sink     in_ch,
  ephb_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ephb_pkg::*;

  localparam int unsigned CELLS = MAX_X_TYPES * MAX_Y_TYPES;
  localparam int unsigned DEPTH = BIN_SLOTS * CELLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [3:0] x_types_r;
  logic [3:0] y_types_r;
  logic [5:0] bins_r;

  // Event state
  logic       session_r;
  logic [5:0] bin_r;
  logic       x_pend_r;
  logic [2:0] held_x_r;
  logic       session_nxt;
  logic [5:0] bin_nxt;
  logic       x_pend_nxt;
  logic [2:0] held_x_nxt;

  // Pipeline control
  logic       s1_valid_r;
  logic       s1_counted_r;
  logic       s1_dropped_r;
  logic       out_valid_r;
  logic [31:0] out_count_r;
  logic       out_counted_r;
  logic       out_dropped_r;

  logic       accept;
  logic       advance;
  logic       busy;
  logic       cfg_wr;
  logic [31:0] rd_count;

  logic [3:0] nx;
  logic [3:0] ny;
  logic [5:0] nb;
  logic       xh;
  logic       yh;
  logic [6:0] pair_cell;
  logic [7:0] cells_used;

  ephb_req_t  req;
  logic [AW-1:0] addr;
  logic       counted;
  logic       dropped;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_types_r <= X_TYPES_RST;
      y_types_r <= Y_TYPES_RST;
      bins_r    <= BINS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_X_TYPES: x_types_r <= pwdata[3:0];
        REG_Y_TYPES: y_types_r <= pwdata[3:0];
        REG_BINS:    bins_r    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X_TYPES: prdata = 32'(x_types_r);
      REG_Y_TYPES: prdata = 32'(y_types_r);
      REG_BINS:    prdata = 32'(bins_r);
      default:     prdata = '0;
    endcase
  end

  // Limit the registers to what the store holds
  always_comb begin
    nx = (7'(x_types_r) > 7'(MAX_X_TYPES)) ? 4'(MAX_X_TYPES) : x_types_r;
    ny = (7'(y_types_r) > 7'(MAX_Y_TYPES)) ? 4'(MAX_Y_TYPES) : y_types_r;
    nb = (9'(bins_r) > 9'(BIN_SLOTS)) ? 6'(BIN_SLOTS) : bins_r;
    xh = in_ch.x_hit && (4'(in_ch.x_index) < nx);
    yh = in_ch.y_hit && (4'(in_ch.y_index) < ny);
    pair_cell  = 7'(held_x_r * ny) + 7'(in_ch.y_index);
    cells_used = nx * ny;
  end

  // Handshake: accept while the read stage can move on
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy && (!s1_valid_r || advance);

  // Decode the transaction: event state update and cell operation
  always_comb begin
    session_nxt = session_r;
    bin_nxt     = bin_r;
    x_pend_nxt  = x_pend_r;
    held_x_nxt  = held_x_r;
    req         = '0;
    addr        = AW'(32'(in_ch.read_bin) * 32'(CELLS)) + AW'(in_ch.read_cell);
    counted     = 1'b0;
    dropped     = 1'b0;
    priority if (in_ch.func) begin
      req.rd = (6'(in_ch.read_bin) < nb) && (8'(in_ch.read_cell) < cells_used);
    end else if (in_ch.is_reset) begin
      session_nxt = 1'b1;
      bin_nxt     = '0;
    end else if (in_ch.is_break) begin
      x_pend_nxt = 1'b0;
    end else if (in_ch.is_bin) begin
      if (!session_r) begin
        session_nxt = 1'b1;
        bin_nxt     = '0;
      end else if (bin_r < BIN_CEILING) begin
        bin_nxt = bin_r + 1'b1;
      end
    end else if (session_r) begin
      if (x_pend_r && yh) begin
        if (bin_r < nb) begin
          req.inc = 1'b1;
          counted = 1'b1;
          addr    = AW'(32'(bin_r) * 32'(CELLS)) + AW'(pair_cell);
        end else begin
          dropped = 1'b1;
        end
        x_pend_nxt = 1'b0;
      end
      if (xh) begin
        held_x_nxt = in_ch.x_index;
        x_pend_nxt = 1'b1;
      end
    end
  end

  // Advance the event state on acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r <= 1'b0;
      bin_r     <= '0;
      x_pend_r  <= 1'b0;
      held_x_r  <= '0;
    end else if (accept) begin
      session_r <= session_nxt;
      bin_r     <= bin_nxt;
      x_pend_r  <= x_pend_nxt;
      held_x_r  <= held_x_nxt;
    end
  end

  ephb_cell_store #(
    .DEPTH       (DEPTH),
    .AW          (AW),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (accept),
    .req      (req),
    .addr     (addr),
    .advance  (advance),
    .busy     (busy),
    .rd_count (rd_count)
  );

  // Read stage flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_counted_r <= counted;
      s1_dropped_r <= dropped;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_count_r   <= rd_count;
      out_counted_r <= s1_counted_r;
      out_dropped_r <= s1_dropped_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.count   = out_count_r;
  assign out_ch.counted = out_counted_r;
  assign out_ch.dropped = out_dropped_r;

  // A pair is either counted or dropped, never both
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_counted_r && out_dropped_r))
    else $error("counted and dropped together");

  // Event results carry no count
  a_event_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_counted_r || out_dropped_r) |-> out_count_r == '0)
    else $error("count on an event result");

  // Nothing accepted while the memory sweep runs
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("ready during clearing sweep");

  // A pair result needs an open session
  a_pair_session: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (counted || dropped) |-> session_r)
    else $error("pair outside a session");

endmodule

>>> hw/rtl/ephb_cell_store.sv
// ----------------------------------------------------------------------------
// ephb_cell_store
// Histogram cell memory with a read-modify-write stage, write forwarding,
// saturating increment and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module ephb_cell_store #(
  parameter int unsigned DEPTH       = 2048,
  parameter int unsigned AW          = 11,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    issue,
  input  ephb_pkg::ephb_req_t     req,
  input  logic [AW-1:0]           addr,
  input  logic                    advance,
  output logic                    busy,
  output logic [31:0]             rd_count
);
  import ephb_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [AW-1:0]          LAST = AW'(DEPTH - 1);

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_r;

  ephb_req_t              s1_req_r;
  logic [AW-1:0]          s1_addr_r;

  logic                   busy_r;
  logic [AW-1:0]          clr_addr_r;

  logic                   wr_last_v_r;
  logic [AW-1:0]          wr_last_addr_r;
  logic [COUNT_WIDTH-1:0] wr_last_data_r;

  logic [COUNT_WIDTH-1:0] cur_val;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [COUNT_WIDTH-1:0] wd;
  logic                   upd;

  assign busy = busy_r;

  // Take the last written value when it targets the cell just read
  always_comb begin
    if (wr_last_v_r && (wr_last_addr_r == s1_addr_r)) begin
      cur_val = wr_last_data_r;
    end else begin
      cur_val = rdata_r;
    end
    cnt_nxt = (cur_val == CMAX) ? cur_val : cur_val + 1'b1;
  end

  // Single write port: clearing sweep or increment write-back
  always_comb begin
    upd = advance && s1_req_r.inc && !busy_r;
    we  = busy_r || upd;
    wa  = busy_r ? clr_addr_r : s1_addr_r;
    wd  = busy_r ? '0 : cnt_nxt;
  end

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rdata_r <= mem[addr];
    end
  end

  // Sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      if (clr_addr_r == LAST) begin
        busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Hold the operation in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_req_r <= '0;
    end else if (issue) begin
      s1_req_r <= req;
    end else if (advance) begin
      s1_req_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr_r <= addr;
    end
  end

  // Remember the latest increment for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_last_v_r <= 1'b0;
    end else if (upd) begin
      wr_last_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      wr_last_addr_r <= s1_addr_r;
      wr_last_data_r <= cnt_nxt;
    end
  end

  // Present the read value, clipped to the result width
  generate
    if (COUNT_WIDTH > OUT_COUNT_W) begin : g_clip
      always_comb begin
        if (!s1_req_r.rd) begin
          rd_count = '0;
        end else if (|cur_val[COUNT_WIDTH-1:OUT_COUNT_W]) begin
          rd_count = '1;
        end else begin
          rd_count = cur_val[OUT_COUNT_W-1:0];
        end
      end
    end else begin : g_ext
      always_comb begin
        rd_count = s1_req_r.rd ? 32'(cur_val) : '0;
      end
    end
  endgenerate

  // No operation enters while the sweep runs
  a_no_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !issue) else $error("issue during clearing sweep");

  // A cell is never both read and incremented
  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_req_r.inc && s1_req_r.rd)) else $error("read and increment together");

  // Each increment lands in the forwarding register
  a_fwd_track: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> wr_last_v_r && (wr_last_addr_r == $past(s1_addr_r)))
    else $error("forwarding register missed a write");

  // The sweep ends only after the last entry
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(clr_addr_r) == LAST)
    else $error("clearing sweep ended early");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for event_pair_binned_histogram. A transaction-level
// predictor of the pair histogram runs beside the block. Each accepted
// transaction is predicted in order, and each result is checked field by
// field against the oldest prediction. Directed tests cover the labels, the
// pairing rules, the register limits and bin saturation. Random traffic
// follows under several register settings and idle/stall profiles.
// ----------------------------------------------------------------------------
module testbench;
  import ephb_pkg::*;

  localparam int unsigned HIST_BINS     = 32;
  localparam int unsigned HIST_X        = 8;
  localparam int unsigned HIST_Y        = 8;
  localparam int unsigned CELLS_PER_BIN = HIST_X * HIST_Y;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned DRAIN_TAIL    = 8;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int unsigned CHUNK_ITEMS   = 60;

  typedef struct packed {
    logic       func;
    logic       is_reset;
    logic       is_break;
    logic       is_bin;
    logic       x_hit;
    logic [2:0] x_index;
    logic       y_hit;
    logic [2:0] y_index;
    logic [4:0] read_bin;
    logic [5:0] read_cell;
  } hist_event_t;

  typedef struct packed {
    logic [31:0] count;
    logic        counted;
    logic        dropped;
  } hist_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ephb_in_if  in_ch ();
  ephb_out_if out_ch ();

  event_pair_binned_histogram i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: registers, session and the cell store
  logic [3:0]   x_types_q;
  logic [3:0]   y_types_q;
  logic [5:0]   bins_q;
  int           bin_now;
  logic         x_held_valid;
  logic [2:0]   x_held;
  logic [31:0]  cell_count [HIST_BINS * CELLS_PER_BIN];
  int           last_bin  = 0;
  int           last_cell = 0;

  hist_result_t awaited_outcomes [$];
  int           err_count   = 0;
  int           idle_pct    = 0;
  int           stall_pct   = 0;
  int unsigned  cycle_count = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("event_pair_binned_histogram regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int limit_to(int v, int cap);
    return (v > cap) ? cap : v;
  endfunction

  // Predict one transaction and advance the histogram state
  function automatic hist_result_t predict_histogram_step(hist_event_t ev);
    hist_result_t res;
    int nx;
    int ny;
    int nb;
    int idx;
    nx  = limit_to(x_types_q, HIST_X);
    ny  = limit_to(y_types_q, HIST_Y);
    nb  = limit_to(bins_q, HIST_BINS);
    res = '0;
    if (ev.func) begin
      if (ev.read_bin < nb && ev.read_cell < nx * ny)
        res.count = cell_count[ev.read_bin * CELLS_PER_BIN + ev.read_cell];
    end else if (ev.is_reset) begin
      bin_now = 0;
    end else if (ev.is_break) begin
      x_held_valid = 1'b0;
    end else if (ev.is_bin) begin
      if (bin_now < int'(BIN_CEILING)) bin_now++;
    end else if (bin_now >= 0) begin
      // Close a pair first, then take a new pending x
      if (x_held_valid && ev.y_hit && ev.y_index < ny) begin
        if (bin_now < nb) begin
          idx = bin_now * CELLS_PER_BIN + x_held * ny + ev.y_index;
          if (cell_count[idx] != '1) cell_count[idx]++;
          res.counted = 1'b1;
          last_bin    = bin_now;
          last_cell   = x_held * ny + ev.y_index;
        end else begin
          res.dropped = 1'b1;
        end
        x_held_valid = 1'b0;
      end
      if (ev.x_hit && ev.x_index < nx) begin
        x_held       = ev.x_index;
        x_held_valid = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic hist_event_t ev_read(int rb, int rc);
    hist_event_t ev;
    ev           = '0;
    ev.func      = 1'b1;
    ev.read_bin  = 5'(rb);
    ev.read_cell = 6'(rc);
    return ev;
  endfunction

  function automatic hist_event_t ev_label(bit rst, bit brk, bit bin);
    hist_event_t ev;
    ev          = '0;
    ev.is_reset = rst;
    ev.is_break = brk;
    ev.is_bin   = bin;
    return ev;
  endfunction

  function automatic hist_event_t ev_pair(bit xh, int xi, bit yh, int yi);
    hist_event_t ev;
    ev         = '0;
    ev.x_hit   = xh;
    ev.x_index = 3'(xi);
    ev.y_hit   = yh;
    ev.y_index = 3'(yi);
    return ev;
  endfunction

  // Random transaction: mostly well-formed events and reads, some noise
  function automatic hist_event_t rand_event();
    hist_event_t ev;
    logic [31:0] raw;
    int pick;
    int nx;
    int ny;
    raw  = $urandom;
    ev   = raw[$bits(hist_event_t)-1:0];
    nx   = limit_to(x_types_q, HIST_X);
    ny   = limit_to(y_types_q, HIST_Y);
    pick = $urandom_range(99);
    if (pick < 12) return ev;
    ev.func     = 1'b0;
    ev.is_reset = 1'b0;
    ev.is_break = 1'b0;
    ev.is_bin   = 1'b0;
    if (pick < 16) begin
      ev.is_reset = 1'b1;
    end else if (pick < 21) begin
      ev.is_break = 1'b1;
    end else if (pick < 28) begin
      ev.is_bin = 1'b1;
    end else if (pick < 43) begin
      ev.func = 1'b1;
      // Aim half the reads at the cell last counted
      if ($urandom_range(1) == 1) begin
        ev.read_bin  = 5'(last_bin);
        ev.read_cell = 6'(last_cell);
      end
    end else begin
      ev.x_hit = ($urandom_range(99) < 55);
      ev.y_hit = ($urandom_range(99) < 55);
      if (nx > 0 && $urandom_range(9) != 0) ev.x_index = 3'($urandom_range(nx - 1));
      if (ny > 0 && $urandom_range(9) != 0) ev.y_index = 3'($urandom_range(ny - 1));
    end
    return ev;
  endfunction

  // Drive one transaction, wait for acceptance, queue its prediction
  task automatic send_event(hist_event_t ev);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= ev.func;
    in_ch.is_reset  <= ev.is_reset;
    in_ch.is_break  <= ev.is_break;
    in_ch.is_bin    <= ev.is_bin;
    in_ch.x_hit     <= ev.x_hit;
    in_ch.x_index   <= ev.x_index;
    in_ch.y_hit     <= ev.y_hit;
    in_ch.y_index   <= ev.y_index;
    in_ch.read_bin  <= ev.read_bin;
    in_ch.read_cell <= ev.read_cell;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    awaited_outcomes.push_back(predict_histogram_step(ev));
  endtask

  // Drop valid and hold until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle
  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr) begin
      case (idx)
        REG_X_TYPES: x_types_q = wdata[3:0];
        REG_Y_TYPES: y_types_q = wdata[3:0];
        REG_BINS:    bins_q    = wdata[5:0];
        default: ;
      endcase
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all three registers on an idle block and read them back
  task automatic set_config(logic [3:0] xt, logic [3:0] yt, logic [5:0] nb);
    logic [31:0] rd;
    drain_results();
    apb_xfer(1'b1, REG_X_TYPES, {28'd0, xt}, rd);
    apb_xfer(1'b1, REG_Y_TYPES, {28'd0, yt}, rd);
    apb_xfer(1'b1, REG_BINS, {26'd0, nb}, rd);
    apb_xfer(1'b0, REG_X_TYPES, '0, rd);
    if (rd !== {28'd0, x_types_q}) report_mismatch($sformatf("x_type_count read %0h", rd));
    apb_xfer(1'b0, REG_Y_TYPES, '0, rd);
    if (rd !== {28'd0, y_types_q}) report_mismatch($sformatf("y_type_count read %0h", rd));
    apb_xfer(1'b0, REG_BINS, '0, rd);
    if (rd !== {26'd0, bins_q}) report_mismatch($sformatf("bins_in_use read %0h", rd));
  endtask

  // Result checker
  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d counted=%0b dropped=%0b",
                                  out_ch.count, out_ch.counted, out_ch.dropped));
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_ch.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", out_ch.count, want.count));
        if (out_ch.counted !== want.counted)
          report_mismatch($sformatf("counted %0b, expected %0b", out_ch.counted, want.counted));
        if (out_ch.dropped !== want.dropped)
          report_mismatch($sformatf("dropped %0b, expected %0b", out_ch.dropped, want.dropped));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Events before any session are ignored; a bin label opens the session
  task automatic test_before_session();
    send_event(ev_read(0, 0));
    send_event(ev_read(31, 63));
    send_event(ev_pair(1, 0, 0, 0));
    send_event(ev_pair(0, 0, 1, 0));
    send_event(ev_label(0, 0, 1));
    send_event(ev_pair(1, 0, 0, 0));
    send_event(ev_pair(0, 0, 1, 0));
    // Read straight after the increment to hit forwarding
    send_event(ev_read(0, 0));
    send_event(ev_read(0, 0));
  endtask

  // Pairing rules: replacement, x-and-y events, break, extreme cells
  task automatic test_pairing();
    send_event(ev_label(1, 0, 0));
    send_event(ev_pair(1, 7, 0, 0));
    send_event(ev_pair(1, 3, 0, 0));
    send_event(ev_pair(0, 0, 1, 7));
    send_event(ev_read(0, 31));
    send_event(ev_pair(1, 2, 1, 5));
    send_event(ev_pair(1, 5, 1, 1));
    send_event(ev_read(0, 17));
    send_event(ev_label(0, 1, 0));
    send_event(ev_pair(0, 0, 1, 0));
    send_event(ev_pair(1, 7, 0, 0));
    send_event(ev_pair(0, 0, 1, 7));
    send_event(ev_read(0, 63));
    send_event(ev_label(0, 0, 1));
    send_event(ev_pair(1, 0, 1, 0));
    send_event(ev_pair(0, 0, 1, 0));
    send_event(ev_read(1, 0));
  endtask

  // Reset beats break beats bin beats x/y; a read ignores the labels
  task automatic test_label_priority();
    hist_event_t ev;
    send_event(ev_pair(1, 4, 0, 0));
    ev          = ev_pair(1, 1, 1, 2);
    ev.is_reset = 1'b1;
    ev.is_break = 1'b1;
    ev.is_bin   = 1'b1;
    send_event(ev);
    send_event(ev_pair(0, 0, 1, 3));
    send_event(ev_pair(1, 6, 0, 0));
    ev          = ev_pair(1, 1, 1, 1);
    ev.is_break = 1'b1;
    ev.is_bin   = 1'b1;
    send_event(ev);
    send_event(ev_pair(0, 0, 1, 1));
    send_event(ev_pair(1, 6, 0, 0));
    ev        = ev_pair(1, 2, 1, 2);
    ev.is_bin = 1'b1;
    send_event(ev);
    send_event(ev_pair(0, 0, 1, 6));
    ev          = ev_read(0, 38);
    ev.is_reset = 1'b1;
    ev.is_break = 1'b1;
    ev.is_bin   = 1'b1;
    ev.x_hit    = 1'b1;
    ev.y_hit    = 1'b1;
    send_event(ev);
    send_event(ev_read(1, 54));
  endtask

  // Type counts, bins in use, limits, zero registers and an unknown index
  task automatic test_register_limits();
    logic [31:0] rd;
    set_config(4'd3, 4'd5, 6'd2);
    apb_xfer(1'b1, REG_UNUSED, 32'hFFFF_FFFF, rd);
    send_event(ev_label(1, 0, 0));
    send_event(ev_pair(1, 5, 0, 0));
    send_event(ev_pair(0, 0, 1, 0));
    send_event(ev_pair(1, 2, 0, 0));
    send_event(ev_pair(0, 0, 1, 5));
    send_event(ev_pair(0, 0, 1, 4));
    send_event(ev_read(0, 14));
    send_event(ev_read(0, 15));
    send_event(ev_read(2, 0));
    send_event(ev_label(0, 0, 1));
    send_event(ev_label(0, 0, 1));
    // Dropped pair still consumes the pending x and takes the new one
    send_event(ev_pair(1, 0, 0, 0));
    send_event(ev_pair(1, 1, 1, 0));
    send_event(ev_pair(0, 0, 1, 0));
    set_config(4'd15, 4'd15, 6'd63);
    send_event(ev_pair(1, 7, 0, 0));
    send_event(ev_pair(0, 0, 1, 7));
    send_event(ev_read(2, 63));
    send_event(ev_read(31, 63));
    set_config(4'd0, 4'd0, 6'd0);
    send_event(ev_pair(1, 0, 0, 0));
    send_event(ev_pair(0, 0, 1, 0));
    send_event(ev_read(0, 0));
    set_config(4'd8, 4'd8, 6'd0);
    send_event(ev_pair(1, 0, 0, 0));
    send_event(ev_pair(0, 0, 1, 0));
  endtask

  // Run the bin counter into its ceiling
  task automatic test_bin_ceiling();
    set_config(4'd8, 4'd8, 6'd32);
    send_event(ev_label(1, 0, 0));
    repeat (70) send_event(ev_label(0, 0, 1));
    send_event(ev_pair(1, 1, 0, 0));
    send_event(ev_pair(0, 0, 1, 1));
    send_event(ev_label(1, 0, 0));
    send_event(ev_pair(1, 1, 0, 0));
    send_event(ev_pair(0, 0, 1, 1));
    send_event(ev_read(0, 9));
  endtask

  // Random traffic over idle/stall profiles and register settings
  task automatic test_random_traffic();
    logic [3:0] xt_set [7] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd2, 4'd8, 4'd0};
    logic [3:0] yt_set [7] = '{4'd8, 4'd1, 4'd15, 4'd5, 4'd8, 4'd3, 4'd6};
    logic [5:0] nb_set [7] = '{6'd32, 6'd1, 6'd63, 6'd4, 6'd6, 6'd2, 6'd8};
    int idle_set  [4] = '{0, 70, 0, 29};
    int stall_set [4] = '{0, 0, 70, 29};
    int chunk;
    for (int ph = 0; ph < 4; ph++) begin
      for (int c = 0; c < 2; c++) begin
        chunk = ph * 2 + c;
        if (chunk < 7)
          set_config(xt_set[chunk], yt_set[chunk], nb_set[chunk]);
        else
          set_config(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                     6'($urandom_range(1, 32)));
        idle_pct  = idle_set[ph];
        stall_pct = stall_set[ph];
        repeat (CHUNK_ITEMS) send_event(rand_event());
        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = 1'b0;
    in_ch.is_reset  = 1'b0;
    in_ch.is_break  = 1'b0;
    in_ch.is_bin    = 1'b0;
    in_ch.x_hit     = 1'b0;
    in_ch.x_index   = '0;
    in_ch.y_hit     = 1'b0;
    in_ch.y_index   = '0;
    in_ch.read_bin  = '0;
    in_ch.read_cell = '0;
    x_types_q       = X_TYPES_RST;
    y_types_q       = Y_TYPES_RST;
    bins_q          = BINS_RST;
    bin_now         = -1;
    x_held_valid    = 1'b0;
    x_held          = '0;
    foreach (cell_count[i]) cell_count[i] = '0;

    // Hold reset, then release on a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_before_session();
    test_pairing();
    test_label_priority();
    test_register_limits();
    test_bin_ceiling();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (err_count == 0) begin
      $display("event_pair_binned_histogram regression: pass");
    end else begin
      $display("event_pair_binned_histogram regression: fail");
    end
    $finish;
  end

endmodule
